// File: rtl/core/sliding_window_score_mean_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding-window score mean core
// Clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SCORE_MEAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_SCORE_MEAN_CORE_MACROS_SVH

// Same-cycle implication
`define SWSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SWSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/swsm_pkg.sv
// ----------------------------------------------------------------------------
// swsm_pkg
// Widths and constants shared by the sliding-window score mean core and its
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package swsm_pkg;

	// Ring capacity and stored score width
	localparam int MAX_UNITS  = 256;
	localparam int SCORE_BITS = 32;

	// Port field widths
	localparam int SCORE_W = 32;
	localparam int WIN_W   = 8;
	localparam int MEAN_W  = 32;

	// Internal widths
	localparam int SUM_W   = 40;
	localparam int RING_AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int FILL_W  = 9;
	localparam int DIVR_W  = 9;

	// Divider: quotient bits retired per cycle and cycles per divide
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = SUM_W / DIV_BITS;
	localparam int DCNT_W     = $clog2(DIV_CYCLES);

endpackage

`default_nettype wire

// File: rtl/core/swsm_ifs.sv
// ----------------------------------------------------------------------------
// swsm channel interfaces
// Valid/ready channels for the input item, the result item and the window
// size register write.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel
interface swsm_item_if import swsm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] unit_score;
	logic               restart;

	modport source (output valid, output unit_score, output restart, input ready);
	modport sink   (input valid, input unit_score, input restart, output ready);
endinterface

// Result item channel
interface swsm_result_if import swsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] mean_score;
	logic              window_full;

	modport source (output valid, output mean_score, output window_full, input ready);
	modport sink   (input valid, input mean_score, input window_full, output ready);
endinterface

// Window size write channel
interface swsm_cfg_if import swsm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window_units;

	modport source (output valid, output window_units, input ready);
	modport sink   (input valid, input window_units, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sliding_window_score_mean_core.sv
// Sequence: an accepted item passes ST_DIV then ST_PUT while filling or on
//   restart; while sliding, ST_RD (ring read, sum update) comes first.
// Flow: a new item is taken only after the last result is loaded; the
//   radix-16 divider retires 4 quotient bits per cycle over the 40-bit sum.
// Reset: arst_n clears sum, fill count, oldest position and sets the window
//   to 8 units; the ring store is not cleared, entries are written before read.
// ----------------------------------------------------------------------------
// sliding_window_score_mean_core
// Keeps the last N scores in a ring memory with a running sum and returns the
// truncated mean sum / N plus a window-full flag for every item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_score_mean_core_macros.svh"

module sliding_window_score_mean_core import swsm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	swsm_cfg_if.sink     cfg,
	swsm_item_if.sink    item,
	swsm_result_if.source result
);

	// Sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUT  = 2'd3;

	logic [1:0]            state_q;
	logic [WIN_W-1:0]      window_units_q;
	logic [SUM_W-1:0]      sum_q;
	logic [FILL_W-1:0]     fill_q;
	logic [RING_AW-1:0]    pos_q;
	logic [DIVR_W-1:0]     n_q;
	logic [SCORE_BITS-1:0] score_q;
	logic                  full_q;
	logic [SUM_W-1:0]      div_q;
	logic [DIVR_W-1:0]     rem_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  out_valid_q;
	logic [MEAN_W-1:0]     out_mean_q;
	logic                  out_full_q;

	logic [SCORE_BITS-1:0] ring_mem [MAX_UNITS];
	logic [SCORE_BITS-1:0] rdata_q;
	logic                  ring_we;
	logic [RING_AW-1:0]    ring_waddr;
	logic [SCORE_BITS-1:0] ring_wdata;

	logic                  item_beat;
	logic [DIVR_W-1:0]     n_eff;
	logic [SCORE_BITS-1:0] in_score;
	logic [SUM_W-1:0]      sum_add;
	logic [SUM_W-1:0]      sum_slide;
	logic [FILL_W-1:0]     fill_inc;
	logic [RING_AW:0]      pos_inc;
	logic                  out_free;
	logic [SUM_W-1:0]      div_nxt;
	logic [DIVR_W-1:0]     rem_nxt;

	// Handshakes
	assign cfg.ready    = 1'b1;
	assign item.ready   = (state_q == ST_IDLE);
	assign item_beat    = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.mean_score  = out_mean_q;
	assign result.window_full = out_full_q;
	assign out_free     = !out_valid_q || result.ready;

	// Effective window size: zero reads as one, clamp to ring capacity
	always_comb begin
		n_eff = {{(DIVR_W-WIN_W){1'b0}}, window_units_q};
		if (n_eff == '0) begin
			n_eff = DIVR_W'(1);
		end
		if (n_eff > DIVR_W'(MAX_UNITS)) begin
			n_eff = DIVR_W'(MAX_UNITS);
		end
	end

	// Sum and position arithmetic
	assign in_score  = item.unit_score[SCORE_BITS-1:0];
	assign sum_add   = sum_q + {{(SUM_W-SCORE_BITS){1'b0}}, in_score};
	assign sum_slide = sum_q - {{(SUM_W-SCORE_BITS){1'b0}}, rdata_q}
		+ {{(SUM_W-SCORE_BITS){1'b0}}, score_q};
	assign fill_inc  = fill_q + FILL_W'(1);
	assign pos_inc   = {1'b0, pos_q} + (RING_AW+1)'(1);

	// Ring write port: restart and fill write at accept, slide writes after read
	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = '0;
		ring_wdata = in_score;
		if (item_beat && item.restart) begin
			ring_we = 1'b1;
		end else if (item_beat && (fill_q < n_eff)) begin
			ring_we    = 1'b1;
			ring_waddr = fill_q[RING_AW-1:0];
		end else if (state_q == ST_RD) begin
			ring_we    = 1'b1;
			ring_waddr = pos_q;
			ring_wdata = score_q;
		end
	end

	// Ring memory, registered read of the oldest entry
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		rdata_q <= ring_mem[pos_q];
	end

	// Divider step: four restoring quotient bits per cycle
	always_comb begin
		logic [DIVR_W:0] trial;
		div_nxt = div_q;
		rem_nxt = rem_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial   = {rem_nxt, div_nxt[SUM_W-1]};
			div_nxt = {div_nxt[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, n_q}) begin
				trial      = trial - {1'b0, n_q};
				div_nxt[0] = 1'b1;
			end
			rem_nxt = trial[DIVR_W-1:0];
		end
	end

	// Window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_units_q <= WIN_W'(8);
		end else if (cfg.valid && cfg.ready) begin
			window_units_q <= cfg.window_units;
		end
	end

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a fresh result or drop the one just taken
			if ((state_q == ST_PUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_beat) begin
						dcnt_q <= '0;
						if (item.restart) begin
							sum_q   <= {{(SUM_W-SCORE_BITS){1'b0}}, in_score};
							fill_q  <= FILL_W'(1);
							pos_q   <= '0;
							state_q <= ST_DIV;
						end else if (fill_q < n_eff) begin
							sum_q   <= sum_add;
							fill_q  <= fill_inc;
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					sum_q   <= sum_slide;
					pos_q   <= (pos_inc >= n_q) ? '0 : pos_inc[RING_AW-1:0];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_CYCLES - 1)) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and divider datapath
	always_ff @(posedge clk) begin
		if (item_beat) begin
			n_q     <= n_eff;
			score_q <= in_score;
			rem_q   <= '0;
			if (item.restart) begin
				div_q  <= {{(SUM_W-SCORE_BITS){1'b0}}, in_score};
				full_q <= (FILL_W'(1) >= n_eff);
			end else if (fill_q < n_eff) begin
				div_q  <= sum_add;
				full_q <= (fill_inc >= n_eff);
			end else begin
				full_q <= 1'b1;
			end
		end else if (state_q == ST_RD) begin
			div_q <= sum_slide;
		end else if (state_q == ST_DIV) begin
			div_q <= div_nxt;
			rem_q <= rem_nxt;
		end
		if ((state_q == ST_PUT) && out_free) begin
			out_mean_q <= div_q[MEAN_W-1:0];
			out_full_q <= full_q;
		end
	end

	// Checks
	`SWSM_ASSERT_NEXT(a_rd_to_div, state_q == ST_RD, state_q == ST_DIV,
		"ring read not followed by divide")
	`SWSM_ASSERT_NEXT(a_div_len, (state_q == ST_DIV) && (dcnt_q == DCNT_W'(DIV_CYCLES - 1)),
		state_q == ST_PUT, "divide did not end after its last step")
	`SWSM_ASSERT_NEXT(a_fill_nonzero, item_beat, fill_q != '0,
		"fill count zero after an accepted item")
	`SWSM_ASSERT_NOW(a_put_free, (state_q == ST_PUT) && out_free && out_valid_q,
		result.ready, "result overwritten before it was taken")

endmodule

`default_nettype wire
